FILE: rtl/fixed_point_alu_macros.svh
// Assertion macros shared by the checker of the fixed-point unit.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define FPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

// Condition that must never hold outside reset.
`define FPA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/fpa_pkg.sv
// Package with types, codes and constants of the fixed-point unit.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int WORD_W            = 32;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_GT       = 4'd4,
    KIND_LT       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_LE       = 4'd7,
    KIND_EQ       = 4'd8,
    KIND_NE       = 4'd9,
    KIND_MIN      = 4'd10,
    KIND_MAX      = 4'd11,
    KIND_INC      = 4'd12,
    KIND_DEC      = 4'd13,
    KIND_TO_INT   = 4'd14,
    KIND_FROM_INT = 4'd15
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]               kind;
    logic signed [WORD_W-1:0] first_value;
    logic signed [WORD_W-1:0] second_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     compare_true;
    logic [1:0]               status;
  } out_beat_t;

  // Context that travels with each item down the pipeline.
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic              neg;
    logic [WORD_W-1:0] res;
    logic              flag;
    status_t           st;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
  } ctx_t;

endpackage

FILE: rtl/fpa_prep.sv
// Decode stage: simple operations, operand magnitudes and divide-by-zero handling.
`timescale 1ns / 1ps
module fpa_prep #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  fpa_pkg::in_beat_t in_beat,
  output fpa_pkg::ctx_t    ctx_out
);

  fpa_pkg::ctx_t ctx_r, ctx_nxt;

  logic signed [31:0] a, b;
  logic signed [32:0] add_s, sub_s, inc_s, dec_s;
  logic [FRACTION_BITS:0] top_bits;
  logic from_ovf;

  always_comb begin
    a        = in_beat.first_value;
    b        = in_beat.second_value;
    add_s    = {a[31], a} + {b[31], b};
    sub_s    = {a[31], a} - {b[31], b};
    inc_s    = {a[31], a} + 33'sd1;
    dec_s    = {a[31], a} - 33'sd1;
    top_bits = a[31:31-FRACTION_BITS];
    from_ovf = !((&top_bits) || !(|top_bits));

    ctx_nxt       = '0;
    ctx_nxt.valid = accept;
    ctx_nxt.kind  = fpa_pkg::kind_t'(in_beat.kind);
    ctx_nxt.st    = fpa_pkg::ST_OK;
    ctx_nxt.neg   = a[31] ^ b[31];
    ctx_nxt.mag_a = a[31] ? 32'(-a) : a;
    ctx_nxt.mag_b = b[31] ? 32'(-b) : b;

    case (fpa_pkg::kind_t'(in_beat.kind))
      fpa_pkg::KIND_ADD: begin
        if (add_s[32] != add_s[31]) begin
          ctx_nxt.st  = fpa_pkg::ST_OVF;
          ctx_nxt.res = add_s[32] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
        end else begin
          ctx_nxt.res = add_s[31:0];
        end
      end
      fpa_pkg::KIND_SUB: begin
        if (sub_s[32] != sub_s[31]) begin
          ctx_nxt.st  = fpa_pkg::ST_OVF;
          ctx_nxt.res = sub_s[32] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
        end else begin
          ctx_nxt.res = sub_s[31:0];
        end
      end
      fpa_pkg::KIND_INC: begin
        if (inc_s[32] != inc_s[31]) begin
          ctx_nxt.st  = fpa_pkg::ST_OVF;
          ctx_nxt.res = fpa_pkg::SAT_MAX;
        end else begin
          ctx_nxt.res = inc_s[31:0];
        end
      end
      fpa_pkg::KIND_DEC: begin
        if (dec_s[32] != dec_s[31]) begin
          ctx_nxt.st  = fpa_pkg::ST_OVF;
          ctx_nxt.res = fpa_pkg::SAT_MIN;
        end else begin
          ctx_nxt.res = dec_s[31:0];
        end
      end
      fpa_pkg::KIND_DIV: begin
        if (b == 32'sd0) begin
          ctx_nxt.st  = fpa_pkg::ST_DIV0;
          ctx_nxt.res = a[31] ? fpa_pkg::SAT_MIN :
                        ((a != 32'sd0) ? fpa_pkg::SAT_MAX : '0);
        end
      end
      fpa_pkg::KIND_GT:  ctx_nxt.flag = a > b;
      fpa_pkg::KIND_LT:  ctx_nxt.flag = a < b;
      fpa_pkg::KIND_GE:  ctx_nxt.flag = a >= b;
      fpa_pkg::KIND_LE:  ctx_nxt.flag = a <= b;
      fpa_pkg::KIND_EQ:  ctx_nxt.flag = a == b;
      fpa_pkg::KIND_NE:  ctx_nxt.flag = a != b;
      fpa_pkg::KIND_MIN: ctx_nxt.res  = (a < b) ? a : b;
      fpa_pkg::KIND_MAX: ctx_nxt.res  = (a > b) ? a : b;
      fpa_pkg::KIND_TO_INT: ctx_nxt.res = a >>> FRACTION_BITS;
      fpa_pkg::KIND_FROM_INT: begin
        if (from_ovf) begin
          ctx_nxt.st  = fpa_pkg::ST_OVF;
          ctx_nxt.res = a[31] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
        end else begin
          ctx_nxt.res = a <<< FRACTION_BITS;
        end
      end
      default: ctx_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.valid <= 1'b0;
    end else begin
      ctx_r <= ctx_nxt;
    end
  end

  assign ctx_out = ctx_r;

endmodule

FILE: rtl/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying the item context.
`timescale 1ns / 1ps
module fpa_div #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fpa_pkg::ctx_t                   ctx_in,
  output fpa_pkg::ctx_t                   ctx_out,
  output logic [fpa_pkg::WORD_W+FRACTION_BITS-1:0] quo_out,
  output logic [fpa_pkg::WORD_W-1:0]      rem_out
);

  localparam int QW = fpa_pkg::WORD_W + FRACTION_BITS;

  fpa_pkg::ctx_t ctx_r [QW];
  logic [31:0]   rem_r [QW];
  logic [QW-1:0] num_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    fpa_pkg::ctx_t c_in;
    logic [31:0]   r_in, shifted, r_nxt;
    logic [QW-1:0] n_in, q_in;
    logic          ge;

    if (i == 0) begin : g_first
      assign c_in = ctx_in;
      assign r_in = '0;
      assign n_in = {ctx_in.mag_a, {FRACTION_BITS{1'b0}}};
      assign q_in = '0;
    end else begin : g_next
      assign c_in = ctx_r[i-1];
      assign r_in = rem_r[i-1];
      assign n_in = num_r[i-1];
      assign q_in = quo_r[i-1];
    end

    always_comb begin
      shifted = {r_in[30:0], n_in[QW-1]};
      ge      = shifted >= c_in.mag_b;
      r_nxt   = ge ? (shifted - c_in.mag_b) : shifted;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctx_r[i].valid <= 1'b0;
      end else begin
        ctx_r[i] <= c_in;
        rem_r[i] <= r_nxt;
        num_r[i] <= {n_in[QW-2:0], 1'b0};
        quo_r[i] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign ctx_out = ctx_r[QW-1];
  assign quo_out = quo_r[QW-1];
  assign rem_out = rem_r[QW-1];

endmodule

FILE: rtl/fpa_mul.sv
// Multiplier stage: registered product of operand magnitudes, divider results passed along.
`timescale 1ns / 1ps
module fpa_mul #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  fpa_pkg::ctx_t                            ctx_in,
  input  logic [fpa_pkg::WORD_W+FRACTION_BITS-1:0] quo_in,
  input  logic [fpa_pkg::WORD_W-1:0]               rem_in,
  output fpa_pkg::ctx_t                            ctx_out,
  output logic [fpa_pkg::WORD_W+FRACTION_BITS-1:0] quo_out,
  output logic [fpa_pkg::WORD_W-1:0]               rem_out,
  output logic [2*fpa_pkg::WORD_W-1:0]             prod_out
);

  fpa_pkg::ctx_t ctx_r;
  logic [fpa_pkg::WORD_W+FRACTION_BITS-1:0] quo_r;
  logic [fpa_pkg::WORD_W-1:0]               rem_r;
  logic [2*fpa_pkg::WORD_W-1:0]             prod_r, prod_nxt;

  assign prod_nxt = ctx_in.mag_a * ctx_in.mag_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.valid <= 1'b0;
    end else begin
      ctx_r  <= ctx_in;
      quo_r  <= quo_in;
      rem_r  <= rem_in;
      prod_r <= prod_nxt;
    end
  end

  assign ctx_out  = ctx_r;
  assign quo_out  = quo_r;
  assign rem_out  = rem_r;
  assign prod_out = prod_r;

endmodule

FILE: rtl/fpa_post.sv
// Rounding, sign and saturation stages that form the output beat.
`timescale 1ns / 1ps
module fpa_post #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  fpa_pkg::ctx_t                            ctx_in,
  input  logic [fpa_pkg::WORD_W+FRACTION_BITS-1:0] quo_in,
  input  logic [fpa_pkg::WORD_W-1:0]               rem_in,
  input  logic [2*fpa_pkg::WORD_W-1:0]             prod_in,
  output logic                                     strobe,
  output fpa_pkg::out_beat_t                       beat
);

  localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  fpa_pkg::ctx_t      ctx_r;
  logic [63:0]        mag_r, mag_nxt;
  logic               rnd;
  fpa_pkg::out_beat_t beat_r, beat_nxt;
  logic               strobe_r;
  logic [31:0]        low;

  // Round step: ties go away from zero since the magnitude is rounded.
  always_comb begin
    rnd = {rem_in, 1'b0} >= {1'b0, ctx_in.mag_b};
    if (ctx_in.kind == fpa_pkg::KIND_MUL) begin
      mag_nxt = (prod_in + HALF) >> FRACTION_BITS;
    end else begin
      mag_nxt = 64'(quo_in) + 64'(rnd);
    end
  end

  always_comb begin
    low      = mag_r[31:0];
    beat_nxt = '0;
    beat_nxt.compare_true = ctx_r.flag;
    beat_nxt.status       = ctx_r.st;
    beat_nxt.result_value = ctx_r.res;
    if ((ctx_r.kind == fpa_pkg::KIND_MUL) ||
        (ctx_r.kind == fpa_pkg::KIND_DIV && ctx_r.st == fpa_pkg::ST_OK)) begin
      if (ctx_r.neg) begin
        if (mag_r > 64'h8000_0000) begin
          beat_nxt.result_value = fpa_pkg::SAT_MIN;
          beat_nxt.status       = fpa_pkg::ST_OVF;
        end else begin
          beat_nxt.result_value = 32'(-low);
        end
      end else begin
        if (mag_r > 64'h7FFF_FFFF) begin
          beat_nxt.result_value = fpa_pkg::SAT_MAX;
          beat_nxt.status       = fpa_pkg::ST_OVF;
        end else begin
          beat_nxt.result_value = low;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.valid <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      ctx_r    <= ctx_in;
      mag_r    <= mag_nxt;
      strobe_r <= ctx_r.valid;
      beat_r   <= beat_nxt;
    end
  end

  assign strobe = strobe_r;
  assign beat   = beat_r;

endmodule

FILE: rtl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point arithmetic unit.
`timescale 1ns / 1ps
// How to use this block:
// The input channel takes one beat (kind, first_value, second_value) at every
// rising edge where start is high and busy is low. The unit never holds off its
// source, so busy stays low and a new beat can enter in every cycle.
// Each accepted beat yields exactly one result beat on out_data, marked by
// out_strobe for a single cycle. The receiver cannot stall, so results simply
// leave in the order their beats came in.
// Every kind takes the same path: one decode stage, one divider stage per
// quotient bit, one multiplier stage, one rounding stage and one
// saturation/output stage. The divider chain is the longest part of the pipe;
// every kind rides the same pipe so order holds.
// Throughput is one beat per cycle.
// Multiply and divide round to nearest with ties away from zero; any result out
// of the 32-bit range saturates and reports overflow. Division by zero reports
// its own status with a result set by the sign of the dividend.
// A synchronous reset clears every valid bit, dropping any beats in flight.
module fixed_point_alu #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fpa_pkg::in_beat_t  in_data,
  output logic               out_strobe,
  output fpa_pkg::out_beat_t out_data
);

  localparam int QW = fpa_pkg::WORD_W + FRACTION_BITS;

  fpa_pkg::ctx_t ctx_prep, ctx_div, ctx_mul;
  logic [QW-1:0] quo_div, quo_mul;
  logic [31:0]   rem_div, rem_mul;
  logic [63:0]   prod_mul;

  // The pipe never backs up, so the input side is always open.
  assign busy = 1'b0;

  fpa_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (start && !busy),
    .in_beat (in_data),
    .ctx_out (ctx_prep)
  );

  fpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctx_in  (ctx_prep),
    .ctx_out (ctx_div),
    .quo_out (quo_div),
    .rem_out (rem_div)
  );

  fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctx_in   (ctx_div),
    .quo_in   (quo_div),
    .rem_in   (rem_div),
    .ctx_out  (ctx_mul),
    .quo_out  (quo_mul),
    .rem_out  (rem_mul),
    .prod_out (prod_mul)
  );

  fpa_post #(.FRACTION_BITS(FRACTION_BITS)) u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctx_in  (ctx_mul),
    .quo_in  (quo_mul),
    .rem_in  (rem_mul),
    .prod_in (prod_mul),
    .strobe  (out_strobe),
    .beat    (out_data)
  );

endmodule

FILE: rtl/fpa_checker.sv
// Port-level checker for the fixed-point unit and its bind statement.
`timescale 1ns / 1ps
`include "fixed_point_alu_macros.svh"
module fpa_checker #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input fpa_pkg::out_beat_t out_data
);

  localparam int LAT = fpa_pkg::WORD_W + FRACTION_BITS + 4;

  `FPA_ASSERT_IMPL(a_latency, start && !busy, ##LAT out_strobe, "result beat missing")
  `FPA_ASSERT_IMPL(a_no_extra, out_strobe, $past(start && !busy, LAT), "unexpected result beat")
  `FPA_ASSERT_IMPL(a_cmp_clean, out_strobe && out_data.compare_true, (out_data.result_value == 32'sd0 && out_data.status == fpa_pkg::ST_OK), "compare beat carries data")
  `FPA_ASSERT_NEVER(a_status_code, out_strobe && out_data.status > fpa_pkg::ST_DIV0, "invalid status code")

endmodule

bind fixed_point_alu fpa_checker #(.FRACTION_BITS(FRACTION_BITS)) u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
